>>> src/cls_lex_pkg.sv
// Package: shared types and constants for the source lexer.
`timescale 1ns / 1ps

package cls_lex_pkg;

    localparam int LineBitsDefault = 24;
    localparam int QueueDepth = 4;

    // token classes
    localparam logic [2:0] CL_IDENT = 3'd0;
    localparam logic [2:0] CL_TRUE  = 3'd1;
    localparam logic [2:0] CL_FALSE = 3'd2;
    localparam logic [2:0] CL_INT   = 3'd3;
    localparam logic [2:0] CL_REAL  = 3'd4;
    localparam logic [2:0] CL_STR   = 3'd5;
    localparam logic [2:0] CL_SYM   = 3'd6;

    // register indexes
    localparam logic [1:0] REG_ANGLE = 2'd0;
    localparam logic [1:0] REG_SPLIT = 2'd1;
    localparam logic [1:0] REG_FIRST = 2'd2;

    // one classified byte handed from front to back
    typedef struct packed {
        logic       eot;
        logic [7:0] ch;
        logic       is_alpha;
        logic       is_digit;
        logic       is_word;
        logic       is_hex;
        logic       is_skip;
    } lex_item_t;

    function automatic lex_item_t classify(input logic eot, input logic [7:0] c);
        lex_item_t r;
        r.eot      = eot;
        r.ch       = c;
        r.is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
        r.is_digit = (c >= 8'h30 && c <= 8'h39);
        r.is_word  = r.is_alpha || r.is_digit || (c == 8'h5f);
        r.is_hex   = r.is_digit || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
        r.is_skip  = (c <= 8'd32) || (c == 8'd127);
        return r;
    endfunction

    // next keyword letter for "true"/"false" progress
    function automatic logic [7:0] kw_next(input logic [3:0] p);
        logic [7:0] r;
        unique case (p)
            4'd1: r = 8'h72;
            4'd2: r = 8'h75;
            4'd3: r = 8'h65;
            4'd5: r = 8'h61;
            4'd6: r = 8'h6c;
            4'd7: r = 8'h73;
            4'd8: r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> src/cls_lex_front.sv
// Front: accepts bytes, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module cls_lex_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_char,
    input  logic                   end_of_text,
    output logic                   q_valid,
    input  logic                   q_ready,
    output cls_lex_pkg::lex_item_t q_item
);

    localparam int AW = $clog2(cls_lex_pkg::QueueDepth);

    cls_lex_pkg::lex_item_t mem_reg [cls_lex_pkg::QueueDepth];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(cls_lex_pkg::QueueDepth));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // pointer and fill count
    always_comb
    begin
        wr_next  = push ? wr_reg + AW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + AW'(1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= cls_lex_pkg::classify(end_of_text, in_char);
        end
    end

endmodule

>>> src/cls_lex_back.sv
// Back: lexer state machine, emits up to three results per byte through an output buffer.
`timescale 1ns / 1ps

module cls_lex_back #(
    parameter int LINE_BITS = cls_lex_pkg::LineBitsDefault
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  cls_lex_pkg::lex_item_t q_item,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_idx,
    input  logic [23:0]            cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_token_end,
    output logic [7:0]             out_char,
    output logic [2:0]             token_class,
    output logic [23:0]            token_line
);

    typedef enum logic [8:0] {
        M_IDLE  = 9'b000000001,
        M_PEND  = 9'b000000010,
        M_LCOM  = 9'b000000100,
        M_BCOM  = 9'b000001000,
        M_BSTAR = 9'b000010000,
        M_IDENT = 9'b000100000,
        M_NUM   = 9'b001000000,
        M_STR   = 9'b010000000,
        M_SESC  = 9'b100000000
    } mode_t;

    typedef struct packed {
        logic       fin;
        logic [7:0] ch;
        logic [2:0] cls;
    } res_t;

    localparam logic [LINE_BITS-1:0] LineMax = '1;

    mode_t          mode_reg, mode_next;
    logic [7:0]     held_reg, held_next;
    logic           flt_reg, flt_next, hex_reg, hex_next, ang_reg, ang_next;
    logic [3:0]     kw_reg, kw_next_v;
    logic [LINE_BITS-1:0] line_reg, line_next, tsl_reg, tsl_next;
    logic           angle_cfg_reg, split_cfg_reg;

    // output buffer: up to three results of one byte, drained one a cycle while out_ready is high
    res_t           buf_reg [3];
    logic [1:0]     bcnt_reg, bidx_reg;
    logic [23:0]    bline_reg;
    // results from bsplit_reg on belong to the token opened by this byte
    logic [23:0]    bnew_reg;
    logic [1:0]     bsplit_reg;

    res_t           r [3];
    logic [1:0]     n;
    logic [1:0]     split;
    logic           take;

    logic [7:0]     c;
    logic [7:0]     h;
    logic           pair;
    logic [7:0]     esc;
    logic           st_go;
    logic [7:0]     st_c;
    logic [2:0]     id_cls;

    assign c = q_item.ch;
    assign h = held_reg;
    assign q_ready = (bcnt_reg == 2'd0) || (out_ready && bidx_reg == bcnt_reg - 2'd1);
    assign take = q_valid && q_ready;

    assign out_valid    = (bcnt_reg != 2'd0);
    assign is_token_end = buf_reg[bidx_reg].fin;
    assign out_char     = buf_reg[bidx_reg].ch;
    assign token_class  = buf_reg[bidx_reg].cls;
    assign token_line   = (bidx_reg >= bsplit_reg) ? bnew_reg : bline_reg;

    // symbol pairs
    always_comb
    begin
        if (c == 8'h3d)
        begin
            pair = (h == 8'h21) || (h == 8'h3c) || (h == 8'h3e) || (h == 8'h2b) ||
                   (h == 8'h2d) || (h == 8'h2a) || (h == 8'h2f) || (h == 8'h5e) ||
                   (h == 8'h7c) || (h == 8'h26) || (h == 8'h7e) || (h == 8'h25) ||
                   (h == 8'h3d);
        end
        else if (h == 8'h3e && c == 8'h3e)
        begin
            pair = !split_cfg_reg;
        end
        else
        begin
            pair = (h == 8'h3c && c == 8'h3c) || (h == 8'h2d && c == 8'h3e) ||
                   (h == 8'h2b && c == 8'h2b) || (h == 8'h2d && c == 8'h2d) ||
                   (h == 8'h26 && c == 8'h26) || (h == 8'h7c && c == 8'h7c) ||
                   (h == 8'h3a && c == 8'h3a);
        end
    end

    always_comb
    begin
        unique case (c)
            8'h6e:   esc = 8'h0a;
            8'h74:   esc = 8'h09;
            8'h72:   esc = 8'h0d;
            default: esc = c;
        endcase
    end

    assign id_cls = (kw_reg == 4'd4) ? cls_lex_pkg::CL_TRUE :
                    (kw_reg == 4'd9) ? cls_lex_pkg::CL_FALSE : cls_lex_pkg::CL_IDENT;

    // main mode update
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        flt_next  = flt_reg;
        hex_next  = hex_reg;
        ang_next  = ang_reg;
        kw_next_v = kw_reg;
        tsl_next  = tsl_reg;
        line_next = line_reg;
        n         = 2'd0;
        split     = 2'd3;
        st_go     = 1'b0;
        st_c      = c;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = '0;
        end

        if (q_item.eot)
        begin
            mode_next = M_IDLE;
            unique case (mode_reg)
                M_PEND:
                begin
                    r[0] = '{1'b0, h, 3'd0};
                    r[1] = '{1'b1, 8'd0, cls_lex_pkg::CL_SYM};
                    n = 2'd2;
                end
                M_IDENT:
                begin
                    r[0] = '{1'b1, 8'd0, id_cls};
                    n = 2'd1;
                end
                M_NUM:
                begin
                    r[0] = '{1'b1, 8'd0, flt_reg ? cls_lex_pkg::CL_REAL : cls_lex_pkg::CL_INT};
                    n = 2'd1;
                end
                M_STR, M_SESC:
                begin
                    r[0] = '{1'b1, 8'd0, cls_lex_pkg::CL_STR};
                    n = 2'd1;
                end
                default: ;
            endcase
        end
        else
        begin
            if (c == 8'h0a && line_reg != LineMax)
            begin
                line_next = line_reg + LINE_BITS'(1);
            end
            unique case (mode_reg)
                M_PEND:
                begin
                    if (h == 8'h2f && c == 8'h2f)
                    begin
                        mode_next = M_LCOM;
                    end
                    else if (h == 8'h2f && c == 8'h2a)
                    begin
                        mode_next = M_BCOM;
                    end
                    else if ((h == 8'h2b || h == 8'h2d) && q_item.is_digit)
                    begin
                        r[0] = '{1'b0, h, 3'd0};
                        r[1] = '{1'b0, c, 3'd0};
                        n = 2'd2;
                        mode_next = M_NUM;
                    end
                    else if (pair)
                    begin
                        r[0] = '{1'b0, h, 3'd0};
                        r[1] = '{1'b0, c, 3'd0};
                        r[2] = '{1'b1, 8'd0, cls_lex_pkg::CL_SYM};
                        n = 2'd3;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        r[0] = '{1'b0, h, 3'd0};
                        r[1] = '{1'b1, 8'd0, cls_lex_pkg::CL_SYM};
                        n = 2'd2;
                        mode_next = M_IDLE;
                        st_go = 1'b1;
                    end
                end
                M_LCOM:
                begin
                    if (c == 8'h0a)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                M_BCOM:
                begin
                    if (c == 8'h2a)
                    begin
                        mode_next = M_BSTAR;
                    end
                end
                M_BSTAR:
                begin
                    if (c == 8'h2f)
                    begin
                        mode_next = M_IDLE;
                    end
                    else if (c != 8'h2a)
                    begin
                        mode_next = M_BCOM;
                    end
                end
                M_IDENT:
                begin
                    if (q_item.is_word)
                    begin
                        kw_next_v = (cls_lex_pkg::kw_next(kw_reg) == c) ? kw_reg + 4'd1 : 4'd0;
                        r[0] = '{1'b0, c, 3'd0};
                        n = 2'd1;
                    end
                    else
                    begin
                        r[0] = '{1'b1, 8'd0, id_cls};
                        n = 2'd1;
                        mode_next = M_IDLE;
                        st_go = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (q_item.is_digit || (!flt_reg && c == 8'h2e) ||
                        (!hex_reg && (c == 8'h78 || c == 8'h58)) || (hex_reg && q_item.is_hex))
                    begin
                        if (c == 8'h2e)
                        begin
                            flt_next = 1'b1;
                        end
                        if (c == 8'h78 || c == 8'h58)
                        begin
                            hex_next = 1'b1;
                        end
                        r[0] = '{1'b0, c, 3'd0};
                        n = 2'd1;
                    end
                    else
                    begin
                        r[0] = '{1'b1, 8'd0,
                                 flt_reg ? cls_lex_pkg::CL_REAL : cls_lex_pkg::CL_INT};
                        n = 2'd1;
                        mode_next = M_IDLE;
                        st_go = !(flt_reg && (c == 8'h66 || c == 8'h46));
                    end
                end
                M_STR:
                begin
                    if (c == (ang_reg ? 8'h3e : 8'h22))
                    begin
                        r[0] = '{1'b1, 8'd0, cls_lex_pkg::CL_STR};
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (c == 8'h5c)
                    begin
                        mode_next = M_SESC;
                    end
                    else
                    begin
                        r[0] = '{1'b0, c, 3'd0};
                        n = 2'd1;
                    end
                end
                M_SESC:
                begin
                    r[0] = '{1'b0, esc, 3'd0};
                    n = 2'd1;
                    mode_next = M_STR;
                end
                default:
                begin
                    mode_next = M_IDLE;
                    st_go = 1'b1;
                end
            endcase

            // token start (at most one character appended, tagged with the new line)
            if (st_go && !q_item.is_skip)
            begin
                tsl_next = line_next;
                flt_next = 1'b0;
                hex_next = 1'b0;
                if (q_item.is_alpha || st_c == 8'h5f)
                begin
                    mode_next = M_IDENT;
                    kw_next_v = (st_c == 8'h74) ? 4'd1 : (st_c == 8'h66) ? 4'd5 : 4'd0;
                    r[n] = '{1'b0, st_c, 3'd0};
                    split = n;
                    n = n + 2'd1;
                end
                else if (q_item.is_digit)
                begin
                    mode_next = M_NUM;
                    r[n] = '{1'b0, st_c, 3'd0};
                    split = n;
                    n = n + 2'd1;
                end
                else if (st_c == 8'h22 || (st_c == 8'h3c && angle_cfg_reg))
                begin
                    mode_next = M_STR;
                    ang_next = (st_c == 8'h3c);
                end
                else
                begin
                    held_next = st_c;
                    mode_next = M_PEND;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            held_reg      <= '0;
            flt_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            ang_reg       <= 1'b0;
            kw_reg        <= '0;
            line_reg      <= '0;
            tsl_reg       <= '0;
            angle_cfg_reg <= 1'b0;
            split_cfg_reg <= 1'b0;
            bcnt_reg      <= '0;
            bidx_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    cls_lex_pkg::REG_ANGLE: angle_cfg_reg <= cfg_data[0];
                    cls_lex_pkg::REG_SPLIT: split_cfg_reg <= cfg_data[0];
                    cls_lex_pkg::REG_FIRST:
                    begin
                        if (LINE_BITS < 24 && (cfg_data >> LINE_BITS) != 24'd0)
                        begin
                            line_reg <= LineMax;
                        end
                        else
                        begin
                            line_reg <= LINE_BITS'(cfg_data);
                        end
                    end
                    default: ;
                endcase
            end
            if (take)
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                flt_reg  <= flt_next;
                hex_reg  <= hex_next;
                ang_reg  <= ang_next;
                kw_reg   <= kw_next_v;
                line_reg <= line_next;
                tsl_reg  <= tsl_next;
                bcnt_reg <= n;
                bidx_reg <= '0;
            end
            else if (out_valid && out_ready)
            begin
                if (bidx_reg == bcnt_reg - 2'd1)
                begin
                    bcnt_reg <= '0;
                    bidx_reg <= '0;
                end
                else
                begin
                    bidx_reg <= bidx_reg + 2'd1;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                buf_reg[i] <= r[i];
            end
            bline_reg  <= 24'(tsl_reg);
            bnew_reg   <= 24'(tsl_next);
            bsplit_reg <= split;
        end
    end

endmodule

>>> src/c_like_source_lexer.sv
// Top level: C-like source lexer, front classifier plus back state machine.
//
//  channel | signals                                       | direction
//  input   | in_valid/in_ready, in_char, end_of_text       | in
//  output  | out_valid/out_ready, is_token_end, out_char,  | out
//          | token_class, token_line                       |
//  config  | cfg_we, cfg_idx, cfg_data                     | in
//
// One byte per cycle when each byte yields at most one result and out_ready is
// high; two or three results hold the back end until the single-result output
// port has drained them. A four-entry queue sits between front and back. Reset
// clears all mode state; line count resets to zero. Either side may stall.
`timescale 1ns / 1ps

module c_like_source_lexer #(
    parameter int LINE_BITS = cls_lex_pkg::LineBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_token_end,
    output logic [7:0]  out_char,
    output logic [2:0]  token_class,
    output logic [23:0] token_line,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [23:0] cfg_data
);

    logic                   q_valid, q_ready;
    cls_lex_pkg::lex_item_t q_item;

    cls_lex_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .end_of_text(end_of_text),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    cls_lex_back #(
        .LINE_BITS(LINE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_token_end(is_token_end),
        .out_char    (out_char),
        .token_class (token_class),
        .token_line  (token_line)
    );

endmodule
